@@ src/prd_pkg.sv @@
// Shared types and constants for the pinhole ray direction unit.
package prd_pkg;

    localparam int MAG_W  = 31;
    localparam int Y_W    = 31;
    localparam int X_W    = 32;
    localparam int Q_W    = 32;
    localparam int T_W    = 32;
    localparam logic [15:0] DIR_LIMIT = 16'd16384;
    localparam logic [33:0] THREE_Q30 = 34'h0_C000_0000;

    typedef enum logic [1:0] {
        REG_CORNER_OFFSET   = 2'd0,
        REG_HORIZONTAL_SPAN = 2'd1,
        REG_VERTICAL_SPAN   = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  degen;
        logic [X_W-1:0]        x;
        logic [Y_W-1:0]        y;
        logic [Q_W-1:0]        q;
        logic [T_W-1:0]        t;
    } ray_t;

    function automatic logic [15:0] rsqrt_seed(input logic [3:0] idx);
        logic [15:0] s;
        unique case (idx)
            4'd4:    s = 16'd61788;
            4'd5:    s = 16'd55889;
            4'd6:    s = 16'd51411;
            4'd7:    s = 16'd47861;
            4'd8:    s = 16'd44957;
            4'd9:    s = 16'd42525;
            4'd10:   s = 16'd40450;
            4'd11:   s = 16'd38651;
            4'd12:   s = 16'd37073;
            4'd13:   s = 16'd35673;
            4'd14:   s = 16'd34421;
            4'd15:   s = 16'd33292;
            default: s = 16'd65535;
        endcase
        return s;
    endfunction

endpackage

@@ src/pinhole_ray_direction_unit.sv @@
// Pinhole camera primary ray direction pipeline.
//
// Input channel s_*: one item per pixel, u and v in unsigned Q0.16.
// Output channel m_*: unit direction x, y, z in signed Q1.14 (saturated to
// +/-16384) and a degenerate flag raised when the summed vector is zero.
// Configuration: cfg_we/cfg_index/cfg_data write the corner offset, the
// horizontal span and the vertical span (x,y,z signed Q8.8 slices); write
// only while no item is in flight.
// One item is accepted per cycle unless the receiver stalls. Each Newton
// step of the inverse square root holds three multiplies, one in each of
// its three stages. Reset clears all valid bits and the configuration
// registers to zero. When the receiver stalls, the whole pipeline holds
// and s_tready falls; nothing is lost.
module pinhole_ray_direction_unit #(
    parameter int RSQRT_ITERATIONS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // u_coord[15:0], v_coord[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    output logic        m_tuser,   // degenerate
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    localparam int N = RSQRT_ITERATIONS;

    logic en;
    logic [47:0] corner_reg, hspan_reg, vspan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= '0;
            hspan_reg  <= '0;
            vspan_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == prd_pkg::REG_CORNER_OFFSET)   corner_reg <= cfg_data;
            if (cfg_index == prd_pkg::REG_HORIZONTAL_SPAN) hspan_reg  <= cfg_data;
            if (cfg_index == prd_pkg::REG_VERTICAL_SPAN)   vspan_reg  <= cfg_data;
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, vo_reg;
    logic [N-1:0] va_reg, vb_reg, vc_reg;

    // stage 1: span products
    logic [2:0][32:0] ph_reg, pv_reg;
    // stage 2: signed sum
    logic [2:0][34:0] mag2_reg;
    logic [2:0]       neg2_reg;
    // stage 3: shift amount
    logic [2:0][34:0] mag3_reg;
    logic [2:0]       neg3_reg;
    logic             zero3_reg, right3_reg;
    logic [4:0]       amt3_reg;
    // stage 4: aligned magnitudes
    logic [2:0][29:0] mag4_reg;
    logic [2:0]       neg4_reg;
    logic             zero4_reg;
    // stage 5: squares
    logic [2:0][59:0] sq5_reg;
    logic [2:0][29:0] mag5_reg;
    logic [2:0]       neg5_reg;
    logic             zero5_reg;
    // stage 6 and Newton steps
    prd_pkg::ray_t r6_reg;
    prd_pkg::ray_t ra_reg [N];
    prd_pkg::ray_t rb_reg [N];
    prd_pkg::ray_t rc_reg [N];
    // stage 7: output products
    logic [2:0][61:0] prod7_reg;
    logic [2:0]       neg7_reg;
    logic             zero7_reg;
    // output
    logic [47:0] dout_reg;
    logic        degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            va_reg <= '0;
            vb_reg <= '0;
            vc_reg <= '0;
            v7_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            for (int i = 0; i < N; i++)
            begin
                va_reg[i] <= (i == 0) ? v6_reg : vc_reg[(i == 0) ? 0 : i - 1];
                vb_reg[i] <= va_reg[i];
                vc_reg[i] <= vb_reg[i];
            end
            v7_reg <= vc_reg[N-1];
            vo_reg <= v7_reg;
        end
    end

    // stage 1
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ph_reg[k] <= $signed({1'b0, s_tdata[15:0]}) * $signed(hspan_reg[16*k +: 16]);
                pv_reg[k] <= $signed({1'b0, s_tdata[31:16]}) * $signed(vspan_reg[16*k +: 16]);
            end
        end
    end

    // stage 2
    logic [2:0][34:0] sum2_next;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum2_next[k] = {{3{corner_reg[16*k+15]}}, corner_reg[16*k +: 16], 16'b0}
                         + {{2{ph_reg[k][32]}}, ph_reg[k]}
                         + {{2{pv_reg[k][32]}}, pv_reg[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                neg2_reg[k] <= sum2_next[k][34];
                mag2_reg[k] <= sum2_next[k][34] ? (35'd0 - sum2_next[k]) : sum2_next[k];
            end
        end
    end

    // stage 3: max and leading one
    logic [34:0] max3;
    logic [5:0]  msb3;
    always_comb
    begin
        max3 = mag2_reg[0];
        if (mag2_reg[1] > max3) max3 = mag2_reg[1];
        if (mag2_reg[2] > max3) max3 = mag2_reg[2];
        msb3 = '0;
        for (int i = 0; i < 35; i++)
        begin
            if (max3[i]) msb3 = 6'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag3_reg   <= mag2_reg;
            neg3_reg   <= neg2_reg;
            zero3_reg  <= (max3 == '0);
            right3_reg <= (msb3 >= 6'd29);
            amt3_reg   <= (msb3 >= 6'd29) ? 5'(msb3 - 6'd29) : 5'(6'd29 - msb3);
        end
    end

    // stage 4: align
    logic [2:0][63:0] sh4;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sh4[k] = right3_reg ? ({29'b0, mag3_reg[k]} >> amt3_reg)
                                : ({29'b0, mag3_reg[k]} << amt3_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++) mag4_reg[k] <= sh4[k][29:0];
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    // stage 5: squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++) sq5_reg[k] <= mag4_reg[k] * mag4_reg[k];
            mag5_reg  <= mag4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
        end
    end

    // stage 6: length squared, range fix, seed
    logic [61:0]   len6, len6_adj;
    logic          small6;
    prd_pkg::ray_t r6_next;
    always_comb
    begin
        len6     = {2'b0, sq5_reg[0]} + {2'b0, sq5_reg[1]} + {2'b0, sq5_reg[2]};
        small6   = (len6[61:60] == 2'b00);
        len6_adj = small6 ? {len6[59:0], 2'b00} : len6;
        r6_next  = '0;
        for (int k = 0; k < 3; k++)
        begin
            r6_next.mag[k] = small6 ? {mag5_reg[k], 1'b0} : {1'b0, mag5_reg[k]};
        end
        r6_next.neg   = neg5_reg;
        r6_next.degen = zero5_reg;
        r6_next.x     = len6_adj[61:30];
        r6_next.y     = {1'b0, prd_pkg::rsqrt_seed(len6_adj[61:58]), 14'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en) r6_reg <= r6_next;
    end

    // Newton steps
    for (genvar g = 0; g < N; g++)
    begin : g_newton
        prd_pkg::ray_t src;
        prd_pkg::ray_t a_next, b_next, c_next;
        logic [61:0] yy;
        logic [63:0] xq;
        logic [62:0] yt;

        if (g == 0)
        begin : g_first
            assign src = r6_reg;
        end
        else
        begin : g_rest
            assign src = rc_reg[g-1];
        end

        always_comb
        begin
            yy = src.y * src.y;
            a_next = src;
            a_next.q = yy[61:30];

            xq = ra_reg[g].x * ra_reg[g].q;
            b_next = ra_reg[g];
            b_next.t = (xq[63:30] >= prd_pkg::THREE_Q30) ? '0
                     : 32'(prd_pkg::THREE_Q30 - xq[63:30]);

            yt = rb_reg[g].y * rb_reg[g].t;
            c_next = rb_reg[g];
            c_next.y = yt[61:31];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ra_reg[g] <= a_next;
                rb_reg[g] <= b_next;
                rc_reg[g] <= c_next;
            end
        end
    end

    // stage 7: scale
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod7_reg[k] <= rc_reg[N-1].mag[k] * rc_reg[N-1].y;
            end
            neg7_reg  <= rc_reg[N-1].neg;
            zero7_reg <= rc_reg[N-1].degen;
        end
    end

    // output: round, saturate, sign
    logic [47:0] dout_next;
    logic [62:0] rnd;
    logic [15:0] mag_o;
    always_comb
    begin
        dout_next = '0;
        rnd       = '0;
        mag_o     = '0;
        for (int k = 0; k < 3; k++)
        begin
            rnd   = {1'b0, prod7_reg[k]} + (63'd1 << 45);
            mag_o = (rnd[62:46] > {1'b0, prd_pkg::DIR_LIMIT}) ? prd_pkg::DIR_LIMIT
                                                               : rnd[61:46];
            dout_next[16*k +: 16] = zero7_reg ? 16'd0
                                  : (neg7_reg[k] ? (16'd0 - mag_o) : mag_o);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg  <= dout_next;
            degen_reg <= zero7_reg;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = dout_reg;
    assign m_tuser  = degen_reg;

endmodule
